FILE: design/fprz_pkg.sv
package fprz_pkg;

  localparam int MAX_LINE_DEF = 2048;
  localparam int MAX_ROWS_DEF = 2048;

  localparam int STEP_W     = 20;
  localparam int ACC_W      = 28;
  localparam int CNT_W      = 12;
  localparam int RUN_W      = 4;
  localparam int PIX_W      = 24;
  localparam int MAX_COPIES = 8;

  localparam logic [STEP_W-1:0] MIN_STEP  = STEP_W'(8192);
  localparam logic [ACC_W-1:0]  HALF_UNIT = ACC_W'(32'h8000);

  // Register index carried by paddr[2].
  localparam logic REG_DUP_STEP = 1'b0;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef struct packed {
    logic src_take;
    logic drn_take;
    logic row_adv;
    logic row_fin;
    logic col_adv;
    logic col_fin;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e in_cmd;
    logic in_line_end;
    logic src_ok;
    logic drn_ok;
    logic row_match;
    logic col_match;
    logic out_free;
  } dp_stat_t;

  // A zero step disables copies; small nonzero steps are raised to one eighth.
  function automatic logic [STEP_W-1:0] eff_step(input logic [STEP_W-1:0] s);
    if (s == '0) begin
      return '0;
    end else if (s < MIN_STEP) begin
      return MIN_STEP;
    end
    return s;
  endfunction

  // Round half up to an integer, kept modulo the counter range.
  function automatic logic [CNT_W-1:0] round_acc(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] sum;
    sum = acc + HALF_UNIT;
    return sum[ACC_W-1:ACC_W-CNT_W];
  endfunction

endpackage

FILE: design/fprz_ctrl.sv
module fprz_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  fprz_pkg::dp_stat_t   stat_i,
  output fprz_pkg::ctrl_cmd_t  cmd_o
);
  import fprz_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROW  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       take;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign take = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          if (stat_i.in_cmd == CMD_PIXEL) begin
            if (stat_i.src_ok) begin
              cmd_o.src_take = 1'b1;
              state_d = stat_i.in_line_end ? S_ROW : S_EMIT;
            end
          end else if (stat_i.drn_ok) begin
            cmd_o.drn_take = 1'b1;
            state_d = S_EMIT;
          end
        end
      end
      S_ROW: begin
        if (stat_i.row_match) begin
          cmd_o.row_adv = 1'b1;
        end else begin
          cmd_o.row_fin = 1'b1;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          if (stat_i.col_match) begin
            cmd_o.col_adv = 1'b1;
          end else begin
            cmd_o.col_fin = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/fprz_dp.sv
module fprz_dp #(
  parameter int MAX_LINE = fprz_pkg::MAX_LINE_DEF,
  parameter int MAX_ROWS = fprz_pkg::MAX_ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fprz_pkg::STEP_W-1:0]  cfg_wdata_i,
  output logic [fprz_pkg::STEP_W-1:0]  dup_step_o,
  input  fprz_pkg::cmd_e               in_cmd_i,
  input  logic [fprz_pkg::PIX_W-1:0]   in_pix_i,
  input  logic                         in_line_end_i,
  input  logic                         in_frame_end_i,
  input  fprz_pkg::ctrl_cmd_t          cmd_i,
  output fprz_pkg::dp_stat_t           stat_o,
  input  logic                         m_tready_i,
  output logic                         m_valid_o,
  output logic [fprz_pkg::PIX_W-1:0]   m_pix_o,
  output logic                         m_row_end_o,
  output logic                         m_frame_end_o,
  output logic                         m_pending_o,
  output logic                         m_last_o
);
  import fprz_pkg::*;

  localparam int AW = $clog2(MAX_LINE);
  localparam int LW = $clog2(MAX_LINE + 1);

  logic [PIX_W-1:0]  line_mem [MAX_LINE];
  logic [PIX_W-1:0]  rd_q;

  logic [STEP_W-1:0] dup_step_q;
  logic [STEP_W-1:0] step;
  logic [ACC_W-1:0]  step_ext;
  logic [ACC_W-1:0]  cfg_step_ext;
  logic [ACC_W-1:0]  col_acc_q, row_acc_q;
  logic [CNT_W-1:0]  col_cnt_q, row_cnt_q;
  logic [RUN_W-1:0]  copies_q, reps_q, rows_left_q;
  logic [LW-1:0]     line_len_q;
  logic [AW-1:0]     replay_col_q;
  logic              frame_pend_q;
  logic              cur_drain_q, fe_q, rend_q, fend_q, pend_q;
  logic [PIX_W-1:0]  pix_q;
  logic              out_valid_q;
  logic              emit;
  logic              store_ok;
  logic [LW:0]       col_next;
  logic              drn_rend;
  logic              row_in_range;

  assign step         = eff_step(dup_step_q);
  assign step_ext     = {{(ACC_W-STEP_W){1'b0}}, step};
  assign cfg_step_ext = {{(ACC_W-STEP_W){1'b0}}, eff_step(cfg_wdata_i)};
  assign dup_step_o   = dup_step_q;

  assign store_ok = (line_len_q < LW'(MAX_LINE));
  assign col_next = {{(LW+1-AW){1'b0}}, replay_col_q} + (LW+1)'(1);
  assign drn_rend = (col_next >= {1'b0, line_len_q});
  assign row_in_range = (row_cnt_q != '0) &&
                        ({1'b0, row_cnt_q} <= (CNT_W+1)'(MAX_ROWS));

  assign emit = cmd_i.col_adv || cmd_i.col_fin;

  assign stat_o.in_cmd      = in_cmd_i;
  assign stat_o.in_line_end = in_line_end_i || in_frame_end_i;
  assign stat_o.src_ok      = (rows_left_q == '0);
  assign stat_o.drn_ok      = (rows_left_q != '0) && (line_len_q != '0);
  assign stat_o.row_match   = (step != '0) && (reps_q < RUN_W'(MAX_COPIES)) &&
                              row_in_range && (round_acc(row_acc_q) == row_cnt_q);
  assign stat_o.col_match   = (step != '0) && (copies_q < RUN_W'(MAX_COPIES)) &&
                              (round_acc(col_acc_q) == col_cnt_q);
  assign stat_o.out_free    = !out_valid_q || m_tready_i;

  // Line store: one write port for incoming pixels, one registered read for replay.
  always_ff @(posedge clk_i) begin
    if (cmd_i.src_take && store_ok) begin
      line_mem[line_len_q[AW-1:0]] <= in_pix_i;
    end
    if (cmd_i.drn_take) begin
      rd_q <= line_mem[replay_col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.src_take) begin
      pix_q <= in_pix_i;
    end
    if (emit) begin
      m_pix_o       <= cur_drain_q ? rd_q : pix_q;
      m_last_o      <= cmd_i.col_fin;
      m_row_end_o   <= cmd_i.col_fin && rend_q;
      m_frame_end_o <= cmd_i.col_fin && fend_q;
      m_pending_o   <= pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dup_step_q   <= '0;
      col_acc_q    <= '0;
      col_cnt_q    <= CNT_W'(1);
      row_acc_q    <= '0;
      row_cnt_q    <= CNT_W'(1);
      copies_q     <= '0;
      reps_q       <= '0;
      rows_left_q  <= '0;
      line_len_q   <= '0;
      replay_col_q <= '0;
      frame_pend_q <= 1'b0;
      cur_drain_q  <= 1'b0;
      fe_q         <= 1'b0;
      rend_q       <= 1'b0;
      fend_q       <= 1'b0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dup_step_q <= cfg_wdata_i;
        col_acc_q  <= cfg_step_ext;
        col_cnt_q  <= CNT_W'(1);
        row_acc_q  <= cfg_step_ext;
        row_cnt_q  <= CNT_W'(1);
      end

      if (cmd_i.src_take) begin
        cur_drain_q <= 1'b0;
        fe_q        <= in_frame_end_i;
        copies_q    <= '0;
        reps_q      <= '0;
        rend_q      <= in_line_end_i || in_frame_end_i;
        fend_q      <= 1'b0;
        pend_q      <= 1'b0;
        if (store_ok) begin
          line_len_q <= line_len_q + LW'(1);
        end
      end

      if (cmd_i.drn_take) begin
        cur_drain_q <= 1'b1;
        copies_q    <= '0;
        rend_q      <= drn_rend;
        fend_q      <= 1'b0;
        pend_q      <= 1'b1;
        if (drn_rend) begin
          replay_col_q <= '0;
          rows_left_q  <= rows_left_q - RUN_W'(1);
          if (rows_left_q == RUN_W'(1)) begin
            pend_q     <= 1'b0;
            line_len_q <= '0;
            if (frame_pend_q) begin
              fend_q       <= 1'b1;
              frame_pend_q <= 1'b0;
            end
          end
        end else begin
          replay_col_q <= replay_col_q + AW'(1);
        end
      end

      if (cmd_i.row_adv) begin
        row_acc_q <= row_acc_q + step_ext;
        reps_q    <= reps_q + RUN_W'(1);
      end

      if (cmd_i.row_fin) begin
        rows_left_q  <= reps_q;
        pend_q       <= (reps_q != '0);
        replay_col_q <= '0;
        row_cnt_q    <= row_cnt_q + CNT_W'(1);
        if (reps_q == '0) begin
          line_len_q <= '0;
        end
        if (fe_q) begin
          // The frame marker moves to the last replayed line when repeats follow.
          if (reps_q == '0) begin
            fend_q <= 1'b1;
          end else begin
            frame_pend_q <= 1'b1;
          end
          row_acc_q <= step_ext;
          row_cnt_q <= CNT_W'(1);
        end
      end

      if (cmd_i.col_adv) begin
        col_acc_q <= col_acc_q + step_ext;
        copies_q  <= copies_q + RUN_W'(1);
      end

      if (cmd_i.col_fin) begin
        col_cnt_q <= col_cnt_q + CNT_W'(1);
        if (rend_q) begin
          col_acc_q <= step_ext;
          col_cnt_q <= CNT_W'(1);
        end
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || m_tready_i))
    else $error("output word overwritten while held");

  a_replay_has_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rows_left_q != '0) |-> (line_len_q != '0))
    else $error("repeats pending with an empty line store");

  a_copy_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (copies_q <= RUN_W'(MAX_COPIES)) && (rows_left_q <= RUN_W'(MAX_COPIES)))
    else $error("copy or repeat count above cap");

  a_src_only_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.src_take |=> (rows_left_q == '0) || $past(stat_o.in_line_end))
    else $error("source pixel taken while repeats pending");
`endif

endmodule

FILE: design/fractional_pixel_replication_zoom_top.sv
// Fractional pixel and line replication zoom.
// Input stream: one word per source pixel (tuser[0] = 0) or per drain request
// (tuser[0] = 1). tlast marks the last pixel of a source line, tuser[1] the
// last pixel of a frame. Output stream: one word per emitted pixel, tlast on
// the last pixel of an output line, tuser flags for frame end, pending line
// repeats and the final word caused by an input word.
// dup_step (APB address 0, Q4.16) sets the copy step; a write restarts the
// line and frame position. Write it only while the block is idle.
// Sequence: an input word is taken in the idle state, then the copy sequencer
// issues its output words one after another, and no new input word is taken
// until the last of them has gone to the output register. A source pixel that
// ends a line first walks the line-repeat accumulator, one repeat at a time.
// Drain words read the line store in the accept cycle, which hides the read.
// A source pixel while repeats are pending, or a drain with none pending, is
// taken and dropped without output. The output word sits in a register: when
// the receiver stalls the sequencer waits, and a new input word can still be
// taken while the last output word waits. Reset clears all control state;
// the line store needs no clearing.
module fractional_pixel_replication_zoom_top #(
  parameter int MAX_LINE = fprz_pkg::MAX_LINE_DEF,
  parameter int MAX_ROWS = fprz_pkg::MAX_ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // red_in, green_in, blue_in
  input  logic        s_axis_tlast_i,  // line_end_in
  input  logic [1:0]  s_axis_tuser_i,  // command, frame_end_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // red_out, green_out, blue_out
  output logic        m_axis_tlast_o,  // row_end_out
  output logic [2:0]  m_axis_tuser_o   // frame_end_out, replay_pending, last_of_run
);
  import fprz_pkg::*;

  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic              cfg_we;
  logic [STEP_W-1:0] dup_step;
  logic              frame_end, pending, last;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i && pready_o &&
                    (paddr_i[2] == REG_DUP_STEP);
  assign prdata_o = (paddr_i[2] == REG_DUP_STEP) ? {{(32-STEP_W){1'b0}}, dup_step} : '0;

  fprz_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  fprz_dp #(
    .MAX_LINE (MAX_LINE),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata_i[STEP_W-1:0]),
    .dup_step_o     (dup_step),
    .in_cmd_i       (cmd_e'(s_axis_tuser_i[0])),
    .in_pix_i       (s_axis_tdata_i),
    .in_line_end_i  (s_axis_tlast_i),
    .in_frame_end_i (s_axis_tuser_i[1]),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .m_tready_i     (m_axis_tready_i),
    .m_valid_o      (m_axis_tvalid_o),
    .m_pix_o        (m_axis_tdata_o),
    .m_row_end_o    (m_axis_tlast_o),
    .m_frame_end_o  (frame_end),
    .m_pending_o    (pending),
    .m_last_o       (last)
  );

  assign m_axis_tuser_o = {last, pending, frame_end};

endmodule

FILE: verif/fractional_pixel_replication_zoom_top_test.sv
module fractional_pixel_replication_zoom_top_test;
  import fprz_pkg::*;

  localparam int LINE_CAP = MAX_LINE_DEF;
  localparam int ROW_CAP = MAX_ROWS_DEF;
  localparam int COL_W = $clog2(LINE_CAP);
  localparam logic [STEP_W-1:0] FLOOR_STEP = STEP_W'(8192);
  localparam logic [STEP_W-1:0] STEP_HALF = STEP_W'(32768);
  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(65536);
  localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(655360);
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic row_end;
    logic frame_end;
    logic pending;
    logic last;
  } pix_t;

  typedef struct packed {
    cmd_e cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic line_end;
    logic frame_end;
  } word_t;

  typedef enum logic [1:0] {CHK_MODEL, CHK_ONE, CHK_NONE} chk_e;

  typedef struct packed {
    logic set_step;
    logic [STEP_W-1:0] step;
    word_t stim;
    chk_e chk;
    pix_t want;
  } vec_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  // Opening rows run with the step at its reset value of zero, so every source
  // word comes straight back once with its own flags; a drain word gives nothing.
  localparam vec_t DIRECTED [25] = '{
    '{0, 0, '{CMD_PIXEL, 'h00, 'h00, 'h00, 0, 0}, CHK_ONE, '{'h00, 'h00, 'h00, 0, 0, 0, 1}},
    '{0, 0, '{CMD_PIXEL, 'hff, 'hff, 'hff, 0, 0}, CHK_ONE, '{'hff, 'hff, 'hff, 0, 0, 0, 1}},
    '{0, 0, '{CMD_PIXEL, 'ha5, 'h5a, 'h3c, 1, 0}, CHK_ONE, '{'ha5, 'h5a, 'h3c, 1, 0, 0, 1}},
    '{0, 0, '{CMD_DRAIN, 'h00, 'h00, 'h00, 0, 0}, CHK_NONE, '0},
    '{0, 0, '{CMD_PIXEL, 'h01, 'h80, 'hfe, 0, 1}, CHK_ONE, '{'h01, 'h80, 'hfe, 1, 1, 0, 1}},
    '{0, 0, '{CMD_PIXEL, 'h7f, 'h01, 'h80, 1, 1}, CHK_ONE, '{'h7f, 'h01, 'h80, 1, 1, 0, 1}},
    '{1, STEP_ONE, '{CMD_PIXEL, 'h10, 'h20, 'h30, 0, 0}, CHK_MODEL, '0},
    '{0, 0, '{CMD_PIXEL, 'hff, 'h00, 'hff, 0, 0}, CHK_MODEL, '0},
    '{0, 0, '{CMD_PIXEL, 'h00, 'hff, 'h00, 1, 0}, CHK_MODEL, '0},
    '{0, 0, '{CMD_PIXEL, 'h12, 'h34, 'h56, 0, 0}, CHK_NONE, '0},
    '{0, 0, '{CMD_DRAIN, 'h00, 'h00, 'h00, 0, 0}, CHK_MODEL, '0},
    '{0, 0, '{CMD_DRAIN, 'h00, 'h00, 'h00, 0, 0}, CHK_MODEL, '0},
    '{0, 0, '{CMD_DRAIN, 'h00, 'h00, 'h00, 0, 0}, CHK_MODEL, '0},
    '{0, 0, '{CMD_DRAIN, 'h00, 'h00, 'h00, 0, 0}, CHK_NONE, '0},
    '{0, 0, '{CMD_PIXEL, 'haa, 'h55, 'hff, 0, 1}, CHK_MODEL, '0},
    '{0, 0, '{CMD_DRAIN, 'h00, 'h00, 'h00, 0, 0}, CHK_MODEL, '0},
    '{1, 100, '{CMD_PIXEL, 'h33, 'hcc, 'h0f, 1, 0}, CHK_MODEL, '0},
    '{1, 20000, '{CMD_PIXEL, 'hc3, 'h3c, 'h99, 1, 1}, CHK_MODEL, '0},
    '{1, STEP_HALF, '{CMD_PIXEL, 'h5a, 'ha5, 'h01, 0, 0}, CHK_MODEL, '0},
    '{0, 0, '{CMD_PIXEL, 'h80, 'h7f, 'hfe, 1, 0}, CHK_MODEL, '0},
    '{0, 0, '{CMD_DRAIN, 'h00, 'h00, 'h00, 0, 0}, CHK_MODEL, '0},
    '{0, 0, '{CMD_DRAIN, 'h00, 'h00, 'h00, 0, 0}, CHK_MODEL, '0},
    '{0, 0, '{CMD_DRAIN, 'h00, 'h00, 'h00, 0, 0}, CHK_MODEL, '0},
    '{0, 0, '{CMD_DRAIN, 'h00, 'h00, 'h00, 0, 0}, CHK_MODEL, '0},
    '{1, STEP_TOP, '{CMD_PIXEL, 'h01, 'h02, 'h04, 1, 1}, CHK_MODEL, '0}
  };

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata_o;
  logic pready_o;
  logic s_tvalid = 1'b0;
  logic s_axis_tready_o;
  logic [23:0] s_tdata = '0;  // red_in, green_in, blue_in
  logic s_tlast = 1'b0;       // line_end_in
  logic [1:0] s_tuser = '0;   // command, frame_end_in
  logic m_axis_tvalid_o;
  logic m_tready = 1'b0;
  logic [23:0] m_axis_tdata_o;  // red_out, green_out, blue_out
  logic m_axis_tlast_o;         // row_end_out
  logic [2:0] m_axis_tuser_o;   // frame_end_out, replay_pending, last_of_run

  idle_e idle_mode = IDLE_NONE;
  int bad_count = 0;

  // Predicted block state.
  logic [STEP_W-1:0] zoom_step = '0;
  logic [ACC_W-1:0] col_acc = '0;
  logic [ACC_W-1:0] row_acc = '0;
  logic [CNT_W-1:0] col_cnt = CNT_W'(1);
  logic [CNT_W-1:0] row_cnt = CNT_W'(1);
  logic [PIX_W-1:0] line_mem [LINE_CAP];
  logic [CNT_W-1:0] line_len = '0;
  logic [RUN_W-1:0] rows_left = '0;
  logic [COL_W-1:0] replay_col = '0;
  logic frame_wait = 1'b0;

  pix_t pix_new [$];
  pix_t pix_due [$];

  fractional_pixel_replication_zoom_top DUT (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [STEP_W-1:0] step_in_use();
    if (zoom_step == '0) begin
      return '0;
    end
    return (zoom_step < FLOOR_STEP) ? FLOOR_STEP : zoom_step;
  endfunction

  function automatic void restart_line();
    col_acc = ACC_W'(step_in_use());
    col_cnt = CNT_W'(1);
  endfunction

  function automatic void restart_frame();
    row_acc = ACC_W'(step_in_use());
    row_cnt = CNT_W'(1);
  endfunction

  // Extra copies while the rounded accumulator still names the current count.
  function automatic int unsigned copies_due(inout logic [ACC_W-1:0] acc,
                                             input logic [CNT_W-1:0] cnt);
    logic [ACC_W-1:0] rounded;
    logic [STEP_W-1:0] st;
    int unsigned n;
    st = step_in_use();
    n = 0;
    if (st == '0) begin
      return 0;
    end
    while (n < MAX_COPIES) begin
      rounded = acc + ACC_W'(32'h8000);
      if (rounded[ACC_W-1:ACC_W-CNT_W] != cnt) begin
        break;
      end
      acc = acc + ACC_W'(st);
      n++;
    end
    return n;
  endfunction

  function automatic void emit_copies(logic [PIX_W-1:0] px);
    int unsigned n;
    pix_t p;
    n = copies_due(col_acc, col_cnt);
    col_cnt = col_cnt + CNT_W'(1);
    p = '{px[23:16], px[15:8], px[7:0], 1'b0, 1'b0, 1'b0, 1'b0};
    repeat (n + 1) pix_new.push_back(p);
  endfunction

  // Works out the pixels one accepted word gives and advances the state.
  function automatic void replicate_word(word_t w);
    int unsigned reps;
    logic row_end;
    logic frame_end;
    pix_new.delete();
    row_end = 1'b0;
    frame_end = 1'b0;
    if (w.cmd == CMD_PIXEL) begin
      if (rows_left != '0) begin
        return;
      end
      if (line_len < LINE_CAP) begin
        line_mem[line_len[COL_W-1:0]] = {w.red, w.green, w.blue};
        line_len = line_len + CNT_W'(1);
      end
      emit_copies({w.red, w.green, w.blue});
      if (w.line_end || w.frame_end) begin
        reps = 0;
        row_end = 1'b1;
        if (row_cnt >= 1 && row_cnt <= ROW_CAP) begin
          reps = copies_due(row_acc, row_cnt);
        end
        row_cnt = row_cnt + CNT_W'(1);
        rows_left = RUN_W'(reps);
        replay_col = '0;
        if (reps == 0) begin
          line_len = '0;
        end
        restart_line();
        if (w.frame_end) begin
          if (reps == 0) begin
            frame_end = 1'b1;
          end else begin
            frame_wait = 1'b1;
          end
          restart_frame();
        end
      end
    end else begin
      if (rows_left == '0 || line_len == '0) begin
        return;
      end
      emit_copies(line_mem[replay_col]);
      if (CNT_W'(replay_col) + CNT_W'(1) >= line_len) begin
        row_end = 1'b1;
        replay_col = '0;
        rows_left = rows_left - RUN_W'(1);
        restart_line();
        if (rows_left == '0) begin
          line_len = '0;
          if (frame_wait) begin
            frame_end = 1'b1;
            frame_wait = 1'b0;
          end
        end
      end else begin
        replay_col = replay_col + COL_W'(1);
      end
    end
    foreach (pix_new[i]) begin
      pix_new[i].pending = (rows_left != '0);
    end
    pix_new[pix_new.size()-1].row_end = row_end;
    pix_new[pix_new.size()-1].frame_end = frame_end;
    pix_new[pix_new.size()-1].last = 1'b1;
  endfunction

  function automatic void note_bad(string tag, pix_t want, pix_t got);
    bad_count++;
    if (bad_count <= 10) begin
      $display("%s: expected %h %h %h row_end=%b frame_end=%b pending=%b last=%b", tag,
               want.red, want.green, want.blue, want.row_end, want.frame_end,
               want.pending, want.last);
      $display("  got %h %h %h row_end=%b frame_end=%b pending=%b last=%b",
               got.red, got.green, got.blue, got.row_end, got.frame_end,
               got.pending, got.last);
    end
  endfunction

  function automatic word_t rand_word(cmd_e cmd, logic le, logic fe);
    word_t w;
    w.cmd = cmd;
    w.red = 8'($urandom_range(255));
    w.green = 8'($urandom_range(255));
    w.blue = 8'($urandom_range(255));
    w.line_end = le;
    w.frame_end = fe;
    return w;
  endfunction

  task automatic send_word(input word_t w, input chk_e chk = CHK_MODEL,
                           input pix_t want = '0);
    int gaps;
    int pct;
    pct = (idle_mode == IDLE_SEND) ? 73 : (idle_mode == IDLE_BOTH) ? 16 : 0;
    gaps = 0;
    while (gaps < 40 && $urandom_range(99) < pct) gaps++;
    if (gaps != 0) begin
      s_tvalid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {w.blue, w.green, w.red};
    s_tlast <= w.line_end;
    s_tuser <= {w.frame_end, w.cmd};
    @(negedge clk);
    while (!s_axis_tready_o) @(negedge clk);
    @(posedge clk);
    replicate_word(w);
    case (chk)
      CHK_MODEL: begin
        foreach (pix_new[i]) pix_due.push_back(pix_new[i]);
      end
      CHK_ONE: begin
        pix_due.push_back(want);
      end
      default: begin
      end
    endcase
  endtask

  // Feeds drain words until no repeated line is left; refused source words are
  // mixed in when asked for.
  task automatic drain_pending(input bit noisy, inout int taken);
    while (rows_left != '0) begin
      if (noisy && $urandom_range(9) == 0) begin
        send_word(rand_word(CMD_PIXEL, 1'($urandom_range(1)), 1'($urandom_range(1))));
      end
      send_word(rand_word(CMD_DRAIN, 1'($urandom_range(1)), 1'($urandom_range(1))));
      taken++;
    end
  endtask

  task automatic wait_idle();
    int guard;
    s_tvalid <= 1'b0;
    guard = 0;
    while (pix_due.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (pix_due.size() != 0) begin
      bad_count += pix_due.size();
      if (bad_count <= 10) begin
        $display("%0d expected words never arrived", pix_due.size());
      end
      pix_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, then read back over a second transfer.
  task automatic set_zoom_step(input logic [STEP_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_DUP_STEP, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready_o) @(negedge clk);
    @(posedge clk);
    zoom_step = value;
    restart_line();
    restart_frame();
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready_o) @(negedge clk);
    if (prdata_o !== 32'(value)) begin
      bad_count++;
      if (bad_count <= 10) begin
        $display("dup_step read back %h, expected %h", prdata_o, 32'(value));
      end
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    case (idle_mode)
      IDLE_RECV: m_tready <= ($urandom_range(99) >= 73);
      IDLE_BOTH: m_tready <= ($urandom_range(99) >= 16);
      default:   m_tready <= 1'b1;
    endcase
  end

  always @(negedge clk) begin
    pix_t got;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got = '{m_axis_tdata_o[7:0], m_axis_tdata_o[15:8], m_axis_tdata_o[23:16],
              m_axis_tlast_o, m_axis_tuser_o[0], m_axis_tuser_o[1], m_axis_tuser_o[2]};
      if (pix_due.size() == 0) begin
        note_bad("unexpected word", '0, got);
      end else if (got !== pix_due[0]) begin
        note_bad("mismatch", pix_due.pop_front(), got);
      end else begin
        void'(pix_due.pop_front());
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int taken;
    int lines;
    int len;
    logic le;
    logic fe;
    logic [STEP_W-1:0] st;
    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].set_step) begin
        wait_idle();
        set_zoom_step(DIRECTED[i].step);
      end
      send_word(DIRECTED[i].stim, DIRECTED[i].chk, DIRECTED[i].want);
    end

    // Random frames: mostly well-formed lines with their repeats drained, with
    // stray drain words and refused source words in between.
    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      idle_mode = idle_e'(ph % 4);
      case (ph)
        0:       st = STEP_TOP;
        1:       st = FLOOR_STEP;
        2:       st = STEP_W'($urandom_range(8191, 1));
        3:       st = STEP_ONE;
        5:       st = '0;
        6:       st = STEP_W'(43691);
        7:       st = STEP_HALF;
        default: st = STEP_W'($urandom_range(655360, 8192));
      endcase
      set_zoom_step(st);
      taken = 0;
      while (taken < 14) begin
        lines = $urandom_range(4, 1);
        for (int l = 1; l <= lines; l++) begin
          len = ($urandom_range(6) == 0) ? 1 : $urandom_range(12, 2);
          for (int c = 1; c <= len; c++) begin
            if ($urandom_range(11) == 0) begin
              send_word(rand_word(CMD_DRAIN, 1'($urandom_range(1)), 1'($urandom_range(1))));
            end
            fe = (c == len) && (l == lines);
            le = (c == len) && !(fe && $urandom_range(2) == 0);
            send_word(rand_word(CMD_PIXEL, le, fe));
            taken++;
          end
          drain_pending(1'b1, taken);
        end
      end
    end

    wait_idle();
    if (bad_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
